@@ design/kata_pkg.sv @@
// Shared types, codes and score arithmetic for the keyed accumulator table.
// Used by keyed_accumulator_table_argmax; has no dependencies of its own.
package kata_pkg;

  localparam int KeyW   = 16;
  localparam int ScoreW = 32;

  // One table entry as it is held in memory.
  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic [KeyW-1:0]          key;
  } entry_t;

  // Operation carried by an input beat.
  typedef enum logic {
    FUNC_ADD    = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  // Status returned with every result beat.
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_EV,
    S_DECIDE,
    S_UPD_RD,
    S_UPD_EV,
    S_DONE
  } state_e;

  // Signed addition that clamps to the 32-bit range.
  function automatic logic signed [ScoreW-1:0] sat_add(
    input logic signed [ScoreW-1:0] a,
    input logic signed [ScoreW-1:0] b
  );
    logic signed [ScoreW:0] sum;
    sum = {a[ScoreW-1], a} + {b[ScoreW-1], b};
    if (sum[ScoreW] != sum[ScoreW-1]) begin
      return sum[ScoreW] ? {1'b1, {(ScoreW-1){1'b0}}} : {1'b0, {(ScoreW-1){1'b1}}};
    end
    return sum[ScoreW-1:0];
  endfunction

endpackage

@@ design/kata_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependencies.
module kata_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered: data appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/keyed_accumulator_table_argmax.sv @@
// Keyed accumulator table with running argmax over positive scores.
// Depends on kata_pkg and on kata_ram for the entry store.
//
// Usage:
//   The slave channel takes one beat per operation: tuser carries the
//   operation (add or remove), tdata the key and the signed Q15.16 delta.
//   The master channel returns exactly one beat per operation: tuser holds
//   the status and the top-valid flag, tdata the top key and its score.
//   Entries live in a single memory of ENTRIES words with one read and one
//   write port. Each operation runs a key search over the stored entries,
//   with a read state and an evaluate state per entry, and stops at the
//   match. Then a rewrite pass applies the update, closes the gap on a
//   remove and tracks the maximum, again with a read state and a write
//   state per entry, over the entry count after the operation.
//   Reset empties the table at once; no clearing pass is needed, since only
//   entries below the count are ever read. A finished result waits in the
//   output register while the next beat is accepted; if the receiver stalls
//   with a result already held, the sequencer waits at its final step.
module keyed_accumulator_table_argmax #(
  parameter int ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] object_key, [47:16] delta
  input  logic        s_axis_tuser,   // [0] func
  // Master side.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] top_key, [47:16] top_score
  output logic [2:0]  m_axis_tuser    // [1:0] status, [2] top_valid
);
  import kata_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  state_e state_q, state_d;

  // Item and progress registers.
  func_e                    func_q, func_d;
  logic [KeyW-1:0]          key_q, key_d;
  logic signed [ScoreW-1:0] delta_q, delta_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            n_q, n_d;
  logic [CW-1:0]            i_q, i_d;
  logic [AW-1:0]            pos_q, pos_d;
  logic                     found_q, found_d;
  logic                     add_hit_q, add_hit_d;
  logic                     rem_hit_q, rem_hit_d;
  logic                     append_q, append_d;
  status_e                  status_q, status_d;

  // Running maximum.
  logic                     top_valid_q, top_valid_d;
  logic [KeyW-1:0]          top_key_q, top_key_d;
  logic signed [ScoreW-1:0] top_score_q, top_score_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q, out_status_d;
  logic                     out_top_valid_q, out_top_valid_d;
  logic [KeyW-1:0]          out_key_q, out_key_d;
  logic signed [ScoreW-1:0] out_score_q, out_score_d;

  // Memory port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  logic          in_accept;
  logic          out_load;
  logic          last_find;
  logic          last_upd;
  logic          key_match;
  logic [CW-1:0] src_idx;
  logic [CW-1:0] n_new;
  status_e       status_new;
  entry_t        upd_entry;

  kata_ram #(
    .Width($bits(entry_t)),
    .Depth(ENTRIES)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake terms and loop ends.
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign last_find = (i_q + CW'(1)) == count_q;
  assign last_upd  = (i_q + CW'(1)) == n_q;
  assign key_match = ram_rdata.key == key_q;

  // Source slot of the rewrite pass: entries above a removed one move down.
  assign src_idx = (rem_hit_q && (i_q >= CW'(pos_q))) ? i_q + CW'(1) : i_q;

  // Outcome of the search: new entry count and status.
  always_comb begin
    n_new      = count_q;
    status_new = ST_DONE;
    if (func_q == FUNC_ADD) begin
      if (!found_q) begin
        if (count_q == CW'(ENTRIES)) begin
          status_new = ST_FULL;
        end else begin
          n_new = count_q + CW'(1);
        end
      end
    end else begin
      if (found_q) begin
        n_new = count_q - CW'(1);
      end else begin
        status_new = ST_NOT_FOUND;
      end
    end
  end

  // Entry value written back to slot i during the rewrite pass.
  always_comb begin
    upd_entry = ram_rdata;
    if (append_q && (i_q == count_q)) begin
      upd_entry.key   = key_q;
      upd_entry.score = delta_q;
    end else if (add_hit_q && (i_q == CW'(pos_q))) begin
      upd_entry.score = sat_add(ram_rdata.score, delta_q);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = (count_q == '0) ? S_DECIDE : S_FIND_RD;
        end
      end
      S_FIND_RD: state_d = S_FIND_EV;
      S_FIND_EV: begin
        state_d = (key_match || last_find) ? S_DECIDE : S_FIND_RD;
      end
      S_DECIDE:  state_d = (n_new == '0) ? S_DONE : S_UPD_RD;
      S_UPD_RD:  state_d = S_UPD_EV;
      S_UPD_EV:  state_d = last_upd ? S_DONE : S_UPD_RD;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Control outputs: handshake and memory ports.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = i_q[AW-1:0];
    ram_waddr     = i_q[AW-1:0];
    ram_wdata     = upd_entry;
    unique case (state_q)
      S_IDLE:    s_axis_tready = 1'b1;
      S_UPD_RD:  ram_raddr = src_idx[AW-1:0];
      S_UPD_EV:  ram_we = 1'b1;
      default:   ram_we = 1'b0;
    endcase
  end

  // Datapath next values.
  always_comb begin
    func_d          = func_q;
    key_d           = key_q;
    delta_d         = delta_q;
    count_d         = count_q;
    n_d             = n_q;
    i_d             = i_q;
    pos_d           = pos_q;
    found_d         = found_q;
    add_hit_d       = add_hit_q;
    rem_hit_d       = rem_hit_q;
    append_d        = append_q;
    status_d        = status_q;
    top_valid_d     = top_valid_q;
    top_key_d       = top_key_q;
    top_score_d     = top_score_q;
    out_valid_d     = out_valid_q && !m_axis_tready;
    out_status_d    = out_status_q;
    out_top_valid_d = out_top_valid_q;
    out_key_d       = out_key_q;
    out_score_d     = out_score_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          func_d  = func_e'(s_axis_tuser);
          key_d   = s_axis_tdata[15:0];
          delta_d = s_axis_tdata[47:16];
          i_d     = '0;
          found_d = 1'b0;
          pos_d   = '0;
        end
      end
      S_FIND_EV: begin
        if (key_match) begin
          found_d = 1'b1;
          pos_d   = i_q[AW-1:0];
        end
        i_d = i_q + CW'(1);
      end
      S_DECIDE: begin
        n_d         = n_new;
        status_d    = status_new;
        add_hit_d   = (func_q == FUNC_ADD) && found_q;
        rem_hit_d   = (func_q == FUNC_REMOVE) && found_q;
        append_d    = (func_q == FUNC_ADD) && !found_q && (status_new == ST_DONE);
        i_d         = '0;
        top_valid_d = 1'b0;
        top_key_d   = '0;
        top_score_d = '0;
      end
      S_UPD_EV: begin
        // Strictly greater keeps the earliest entry on a tie.
        if ((upd_entry.score > 0) && (!top_valid_q || (upd_entry.score > top_score_q))) begin
          top_valid_d = 1'b1;
          top_key_d   = upd_entry.key;
          top_score_d = upd_entry.score;
        end
        i_d = i_q + CW'(1);
      end
      S_DONE: begin
        if (out_load) begin
          count_d         = n_q;
          out_valid_d     = 1'b1;
          out_status_d    = status_q;
          out_top_valid_d = top_valid_q;
          out_key_d       = top_key_q;
          out_score_d     = top_score_q;
        end
      end
      default: begin
        i_d = i_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q          <= func_d;
    key_q           <= key_d;
    delta_q         <= delta_d;
    n_q             <= n_d;
    i_q             <= i_d;
    pos_q           <= pos_d;
    found_q         <= found_d;
    add_hit_q       <= add_hit_d;
    rem_hit_q       <= rem_hit_d;
    append_q        <= append_d;
    status_q        <= status_d;
    top_valid_q     <= top_valid_d;
    top_key_q       <= top_key_d;
    top_score_q     <= top_score_d;
    out_status_q    <= out_status_d;
    out_top_valid_q <= out_top_valid_d;
    out_key_q       <= out_key_d;
    out_score_q     <= out_score_d;
  end

  // Result beat.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_score_q, out_key_q};
  assign m_axis_tuser  = {out_top_valid_q, out_status_q};

  // The entry count never exceeds the table size.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count above table size");

  // A dropped add is only ever reported against a full table.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == ST_FULL)) |-> (count_q == CW'(ENTRIES)))
    else $error("full status with free entries");

  // A reported top entry always has a positive score; none reports zeros.
  a_top_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_top_valid_q) |-> (out_score_q > 0))
    else $error("top entry without positive score");

  a_top_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_top_valid_q) |-> ((out_key_q == '0) && (out_score_q == '0)))
    else $error("empty top result not cleared");

  // An accepted beat always starts work before the next one can be taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("second beat accepted while busy");

endmodule
